### design/spq_pkg.sv
// ============================================================================
// spq_pkg
// Shared types and codes for the sorted priority queue.
// ============================================================================
package spq_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int IN_PRIO_BITS = 8;
    localparam int COUNT_BITS  = 5;

    // command codes
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } spq_status_t;

    // operation broadcast to every cell, already qualified
    typedef struct packed {
        logic enq;
        logic deq;
    } spq_op_t;

endpackage

### design/spq_cell.sv
// ============================================================================
// spq_cell
// One slot of the sorted chain: holds a value and its priority, compares
// against the incoming priority and shifts with its neighbors.
// ============================================================================
module spq_cell #(
    parameter int PRIORITY_BITS = 8
) (
    input  logic                                clk,
    input  spq_pkg::spq_op_t                    op,
    input  logic                                occupied,
    input  logic [spq_pkg::VALUE_BITS-1:0]      new_value,
    input  logic [PRIORITY_BITS-1:0]            new_prio,
    input  logic                                prev_after,
    input  logic [spq_pkg::VALUE_BITS-1:0]      prev_value,
    input  logic [PRIORITY_BITS-1:0]            prev_prio,
    input  logic [spq_pkg::VALUE_BITS-1:0]      next_value,
    input  logic [PRIORITY_BITS-1:0]            next_prio,
    output logic                                after,
    output logic [spq_pkg::VALUE_BITS-1:0]      value,
    output logic [PRIORITY_BITS-1:0]            prio
);

    logic [spq_pkg::VALUE_BITS-1:0] value_reg, value_next;
    logic [PRIORITY_BITS-1:0]       prio_reg, prio_next;

    // new entry goes behind this one (ties stay FIFO)
    assign after = occupied && (prio_reg <= new_prio);

    always_comb
    begin
        value_next = value_reg;
        prio_next  = prio_reg;
        if (op.enq && !after)
        begin
            if (prev_after)
            begin
                value_next = new_value;
                prio_next  = new_prio;
            end
            else
            begin
                value_next = prev_value;
                prio_next  = prev_prio;
            end
        end
        else if (op.deq)
        begin
            value_next = next_value;
            prio_next  = next_prio;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    assign value = value_reg;
    assign prio  = prio_reg;

endmodule

### design/sorted_priority_queue.sv
// ============================================================================
// sorted_priority_queue
// Bounded priority queue kept as a sorted chain of slot cells.
// ============================================================================
// A transaction on the input side is either an enqueue (value plus priority)
// or a dequeue; each one yields exactly one result transaction in the next
// cycle, carrying the removed value (zero unless a dequeue succeeded), a
// status and the entry count after the operation. Unless the input stalls,
// the queue takes one transaction per cycle: each cell compares its stored
// priority with the incoming one in the same cycle; an enqueue moves the
// cells behind its slot one place back, a dequeue the whole row one place
// forward, so an operation costs one compare per cell plus the neighbor
// handoff. Lower priority numbers leave first, ties in arrival order.
// The input stalls only while a result is held in the output register and
// downstream stalls. Slots have no reset; count and valid flag are cleared.
module sorted_priority_queue #(
    parameter int CAPACITY      = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  command,
    input  logic signed [spq_pkg::VALUE_BITS-1:0] item_value,
    input  logic [spq_pkg::IN_PRIO_BITS-1:0]      item_priority,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [spq_pkg::VALUE_BITS-1:0] out_value,
    output logic [1:0]                            status,
    output logic [spq_pkg::COUNT_BITS-1:0]        entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // ---- state ----
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic                             out_valid_reg, out_valid_next;
    logic [spq_pkg::VALUE_BITS-1:0]   out_value_reg, out_value_next;
    spq_pkg::spq_status_t             status_reg, status_next;
    logic [CNT_W-1:0]                 ecount_reg, ecount_next;

    // ---- chain wiring ----
    logic [spq_pkg::VALUE_BITS-1:0]   cell_value [CAPACITY];
    logic [PRIORITY_BITS-1:0]         cell_prio  [CAPACITY];
    logic [CAPACITY-1:0]              cell_after;
    logic [CAPACITY-1:0]              cell_occ;

    logic                             accept;
    logic                             full;
    logic                             empty;
    logic [PRIORITY_BITS-1:0]         prio_in;
    spq_pkg::spq_op_t                 op;

    // priority taken modulo 2^PRIORITY_BITS
    generate
        if (PRIORITY_BITS > spq_pkg::IN_PRIO_BITS)
        begin : g_prio_ext
            assign prio_in = {{(PRIORITY_BITS - spq_pkg::IN_PRIO_BITS){1'b0}}, item_priority};
        end
        else if (PRIORITY_BITS == spq_pkg::IN_PRIO_BITS)
        begin : g_prio_eq
            assign prio_in = item_priority;
        end
        else
        begin : g_prio_trunc
            assign prio_in = item_priority[PRIORITY_BITS-1:0];
        end
    endgenerate

    // result register frees up when it is empty or being taken
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);

    assign op.enq = accept && (command == spq_pkg::CMD_ENQ) && !full;
    assign op.deq = accept && (command == spq_pkg::CMD_DEQ) && !empty;

    // ---- the row of cells; slot 0 is the front ----
    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                           p_after;
            logic [spq_pkg::VALUE_BITS-1:0] p_value;
            logic [PRIORITY_BITS-1:0]       p_prio;
            logic [spq_pkg::VALUE_BITS-1:0] n_value;
            logic [PRIORITY_BITS-1:0]       n_prio;

            assign cell_occ[i] = (CNT_W'(i) < count_reg);

            if (i == 0)
            begin : g_first
                assign p_after = 1'b1;
                assign p_value = item_value;
                assign p_prio  = prio_in;
            end
            else
            begin : g_mid
                assign p_after = cell_after[i-1];
                assign p_value = cell_value[i-1];
                assign p_prio  = cell_prio[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign n_value = cell_value[i];
                assign n_prio  = cell_prio[i];
            end
            else
            begin : g_inner
                assign n_value = cell_value[i+1];
                assign n_prio  = cell_prio[i+1];
            end

            spq_cell #(
                .PRIORITY_BITS (PRIORITY_BITS)
            ) u_cell (
                .clk        (clk),
                .op         (op),
                .occupied   (cell_occ[i]),
                .new_value  (item_value),
                .new_prio   (prio_in),
                .prev_after (p_after),
                .prev_value (p_value),
                .prev_prio  (p_prio),
                .next_value (n_value),
                .next_prio  (n_prio),
                .after      (cell_after[i]),
                .value      (cell_value[i]),
                .prio       (cell_prio[i])
            );
        end
    endgenerate

    // ---- count and result ----
    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_value_next = out_value_reg;
        status_next    = status_reg;
        ecount_next    = ecount_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_value_next = '0;
            status_next    = spq_pkg::ST_OK;
            case (command)
                spq_pkg::CMD_ENQ:
                begin
                    if (full)
                        status_next = spq_pkg::ST_FULL;
                    else
                        count_next = count_reg + CNT_W'(1);
                end
                spq_pkg::CMD_DEQ:
                begin
                    if (empty)
                        status_next = spq_pkg::ST_EMPTY;
                    else
                    begin
                        count_next     = count_reg - CNT_W'(1);
                        out_value_next = cell_value[0];
                    end
                end
                default:
                begin
                    status_next = spq_pkg::ST_OK;
                end
            endcase
            ecount_next = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        status_reg    <= status_next;
        ecount_reg    <= ecount_next;
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign status    = status_reg;

    // count shown modulo 32
    generate
        if (CNT_W >= spq_pkg::COUNT_BITS)
        begin : g_cnt_trunc
            assign entry_count = ecount_reg[spq_pkg::COUNT_BITS-1:0];
        end
        else
        begin : g_cnt_ext
            assign entry_count = {{(spq_pkg::COUNT_BITS - CNT_W){1'b0}}, ecount_reg};
        end
    endgenerate

    // ---- assertions ----
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command == spq_pkg::CMD_ENQ && full)
        |=> (out_valid && status == spq_pkg::ST_FULL && $stable(count_reg)))
        else $error("enqueue into full queue not rejected");

    a_deq_front: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command == spq_pkg::CMD_DEQ && !empty)
        |=> (out_value == $past(cell_value[0]) && status == spq_pkg::ST_OK))
        else $error("dequeue did not return front entry");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(ecount_reg)))
        else $error("stalled result lost");

endmodule
